@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the Bezier point evaluator.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define BPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BPE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/bpe_pkg.sv @@
// Package of the Bezier point evaluator: widths, types and register indexes.
// Used by every module of the block; depends on nothing.
package bpe_pkg;

	localparam int T_W      = 13;
	localparam int T_SW     = T_W + 1;
	localparam int ONE_T    = 4096;
	localparam int PT_W     = 24;
	localparam int COEF_W   = 28;
	localparam int AT_W     = COEF_W + T_SW;
	localparam int H1_W     = 46;
	localparam int P2_W     = H1_W + T_SW;
	localparam int H2_W     = P2_W + 1;
	localparam int P3_W     = H2_W + T_SW;
	localparam int POS_W    = 24;
	localparam int VEL_W    = 27;
	localparam int ACC_W    = 29;
	localparam int NV_W     = 51;
	localparam int SPD_W    = 27;
	localparam int RAD_W    = 2 * SPD_W;
	localparam int REM_W    = SPD_W + 3;
	localparam int SUM_W    = 104;
	localparam int NORM_LAT = 3 + SPD_W;
	localparam int IDX_W    = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
		REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
	} reg_idx_t;

	// Power-basis coefficients of one axis.
	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [PT_W-1:0]   d;
	} coef_t;

	// Floored results of one axis.
	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic signed [VEL_W-1:0] vel;
		logic signed [ACC_W-1:0] acc;
	} axis_res_t;

endpackage

@@ src/bpe_axis.sv @@
// One axis of the evaluator: Horner evaluation of position, velocity and acceleration.
// Depends on bpe_pkg; six register stages, s2 to s7.
module bpe_axis import bpe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [T_W-1:0]         t_in,
	input  coef_t                  coef,
	output logic                   out_valid,
	output axis_res_t              res,
	output logic signed [NV_W-1:0] nv
);

	logic                    v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [T_W-1:0]          t_s2, t_s3, t_s4, t_s5;
	logic signed [AT_W-1:0]  at_s2;
	logic signed [H1_W-1:0]  h1_s3, g1_s3;
	logic signed [ACC_W-1:0] acc_s3, acc_s4, acc_s5, acc_s6, acc_s7;
	logic signed [P2_W-1:0]  h2p_s4, gp_s4;
	logic signed [H2_W-1:0]  h2_s5;
	logic signed [NV_W-1:0]  nv_s5, nv_s6, nv_s7;
	logic signed [VEL_W-1:0] vel_s5, vel_s6, vel_s7;
	logic signed [P3_W-1:0]  pp_s6;
	logic signed [POS_W-1:0] pos_s7;

	logic signed [T_SW-1:0]  t_in_x, t_s3_x, t_s5_x;
	logic signed [H1_W-1:0]  at_w, b_w, h1_n, g1_n, acc_n;
	logic signed [H2_W-1:0]  c_w, h2_n, nv_n;

	assign t_in_x = signed'({1'b0, t_in});
	assign t_s3_x = signed'({1'b0, t_s3});
	assign t_s5_x = signed'({1'b0, t_s5});

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Inner Horner terms: a*t + b, and the derivative forms 3a*t + 2b and 6a*t + 2b.
	always_comb begin
		at_w  = H1_W'(at_s2);
		b_w   = H1_W'(coef.b);
		h1_n  = at_w + (b_w <<< 12);
		g1_n  = (at_w <<< 1) + at_w + (b_w <<< 13);
		acc_n = (at_w <<< 2) + (at_w <<< 1) + (b_w <<< 13);
	end

	// Outer terms add c, scaled to the fraction bits already carried.
	always_comb begin
		c_w  = H2_W'(coef.c);
		h2_n = H2_W'(h2p_s4) + (c_w <<< 24);
		nv_n = H2_W'(gp_s4) + (c_w <<< 24);
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		t_s2   <= t_in;
		at_s2  <= coef.a * t_in_x;

		t_s3   <= t_s2;
		h1_s3  <= h1_n;
		g1_s3  <= g1_n;
		acc_s3 <= ACC_W'(acc_n >>> 12);

		t_s4   <= t_s3;
		h2p_s4 <= h1_s3 * t_s3_x;
		gp_s4  <= g1_s3 * t_s3_x;
		acc_s4 <= acc_s3;

		t_s5   <= t_s4;
		h2_s5  <= h2_n;
		nv_s5  <= NV_W'(nv_n);
		vel_s5 <= VEL_W'(nv_n >>> 24);
		acc_s5 <= acc_s4;

		pp_s6  <= h2_s5 * t_s5_x;
		nv_s6  <= nv_s5;
		vel_s6 <= vel_s5;
		acc_s6 <= acc_s5;

		// Arithmetic shift floors; d holds the integer part exactly.
		pos_s7 <= POS_W'(pp_s6 >>> 36) + coef.d;
		nv_s7  <= nv_s6;
		vel_s7 <= vel_s6;
		acc_s7 <= acc_s6;
	end

	assign out_valid = v_s7;
	assign res.pos   = pos_s7;
	assign res.vel   = vel_s7;
	assign res.acc   = acc_s7;
	assign nv        = nv_s7;

endmodule

@@ src/bpe_norm.sv @@
// Speed unit: floor of the norm of the derivative, scaled down by 2^24.
// Depends on bpe_pkg; three arithmetic stages and one square-root stage per result bit.
module bpe_norm import bpe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic signed [NV_W-1:0] nv_x,
	input  logic signed [NV_W-1:0] nv_y,
	output logic                   out_valid,
	output logic [SPD_W-1:0]       speed
);

	localparam int HI_W = NV_W - 24;

	logic                  v_n1, v_n2, v_n3;
	logic [NV_W-1:0]       ax_n1, ay_n1;
	logic [2*HI_W-1:0]     hhx_n2, hhy_n2;
	logic [HI_W+23:0]      hlx_n2, hly_n2;
	logic [47:0]           llx_n2, lly_n2;
	logic [RAD_W-1:0]      rad_n3;
	logic [SUM_W-1:0]      sum_n;

	logic                  sv_q   [SPD_W];
	logic [REM_W-1:0]      rem_q  [SPD_W];
	logic [SPD_W-1:0]      root_q [SPD_W];
	logic [RAD_W-1:0]      rad_q  [SPD_W];

	// Sum of squares from split partial products.
	always_comb begin
		sum_n = ((SUM_W'(hhx_n2) + SUM_W'(hhy_n2)) << 48)
			+ ((SUM_W'(hlx_n2) + SUM_W'(hly_n2)) << 25)
			+ SUM_W'(llx_n2) + SUM_W'(lly_n2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n1 <= 1'b0;
			v_n2 <= 1'b0;
			v_n3 <= 1'b0;
		end else begin
			v_n1 <= in_valid;
			v_n2 <= v_n1;
			v_n3 <= v_n2;
		end
	end

	always_ff @(posedge clk) begin
		ax_n1  <= nv_x[NV_W-1] ? NV_W'(-nv_x) : NV_W'(nv_x);
		ay_n1  <= nv_y[NV_W-1] ? NV_W'(-nv_y) : NV_W'(nv_y);
		hhx_n2 <= ax_n1[NV_W-1:24] * ax_n1[NV_W-1:24];
		hhy_n2 <= ay_n1[NV_W-1:24] * ay_n1[NV_W-1:24];
		hlx_n2 <= ax_n1[NV_W-1:24] * ax_n1[23:0];
		hly_n2 <= ay_n1[NV_W-1:24] * ay_n1[23:0];
		llx_n2 <= ax_n1[23:0] * ax_n1[23:0];
		lly_n2 <= ay_n1[23:0] * ay_n1[23:0];
		rad_n3 <= sum_n[48 +: RAD_W];
	end

	// Digit-by-digit square root, one result bit per stage.
	for (genvar k = 0; k < SPD_W; k++) begin : g_sqrt
		logic [REM_W-1:0] rem_in, cand, trial;
		logic [SPD_W-1:0] root_in;
		logic [RAD_W-1:0] rad_in;
		logic             v_in;

		if (k == 0) begin : g_first
			assign v_in    = v_n3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_n3;
		end else begin : g_next
			assign v_in    = sv_q[k-1];
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign rad_in  = rad_q[k-1];
		end

		assign cand  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_q[k] <= 1'b0;
			end else begin
				sv_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_q[k] <= {rad_in[RAD_W-3:0], 2'b00};
			if (cand >= trial) begin
				rem_q[k]  <= cand - trial;
				root_q[k] <= {root_in[SPD_W-2:0], 1'b1};
			end else begin
				rem_q[k]  <= cand;
				root_q[k] <= {root_in[SPD_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = sv_q[SPD_W-1];
	assign speed     = root_q[SPD_W-1];

endmodule

@@ src/bezier_point_evaluator.sv @@
// Cubic Bezier evaluator: one t per cycle, every cycle; busy is always low.
// Each accepted t gives one result; done is high for a single cycle per result, and
// the receiver cannot stall. The result passes the input register, six Horner stages,
// three norm stages, one square-root stage per speed bit and the output register.
// Asynchronous active-low reset clears all valid bits and the control points
// (to zero); items in flight are dropped.
module bezier_point_evaluator import bpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [T_W-1:0]          t_value,
	input  logic                    wr_en,
	input  logic [IDX_W-1:0]        wr_index,
	input  logic [PT_W-1:0]         wr_data,
	output logic                    done,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic signed [ACC_W-1:0] acc_x,
	output logic signed [ACC_W-1:0] acc_y,
	output logic [SPD_W-1:0]        speed_mag
);

	`include "assert_macros.svh"

	localparam int LAT = 8 + NORM_LAT;

	logic signed [PT_W-1:0] p_q [8];
	coef_t                  coef_q [2];
	coef_t                  coef_n [2];

	logic                   v_s1;
	logic [T_W-1:0]         t_s1;
	logic                   accept;

	logic                   ax_valid [2];
	axis_res_t              ax_res [2];
	logic signed [NV_W-1:0] ax_nv [2];

	logic                   nrm_valid;
	logic [SPD_W-1:0]       nrm_speed;

	logic                   dv_q [NORM_LAT];
	axis_res_t              dx_q [NORM_LAT];
	axis_res_t              dy_q [NORM_LAT];

	logic                   done_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Control point registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				p_q[i] <= '0;
			end
		end else if (wr_en) begin
			p_q[wr_index] <= wr_data;
		end
	end

	// Power-basis coefficients, registered once per cycle from the control points.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			logic signed [COEF_W-1:0] q0, q1, q2, q3, d12, e, d01;
			q0  = COEF_W'(p_q[i]);
			q1  = COEF_W'(p_q[2 + i]);
			q2  = COEF_W'(p_q[4 + i]);
			q3  = COEF_W'(p_q[6 + i]);
			d12 = q1 - q2;
			e   = q0 - (q1 <<< 1) + q2;
			d01 = q1 - q0;
			coef_n[i].a = q3 - q0 + (d12 <<< 1) + d12;
			coef_n[i].b = (e <<< 1) + e;
			coef_n[i].c = (d01 <<< 1) + d01;
			coef_n[i].d = p_q[i];
		end
	end

	always_ff @(posedge clk) begin
		coef_q[0] <= coef_n[0];
		coef_q[1] <= coef_n[1];
	end

	// Input stage: t above one is held at one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= (t_value > T_W'(ONE_T)) ? T_W'(ONE_T) : t_value;
	end

	for (genvar g = 0; g < 2; g++) begin : g_axis
		bpe_axis u_axis (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_s1),
			.t_in      (t_s1),
			.coef      (coef_q[g]),
			.out_valid (ax_valid[g]),
			.res       (ax_res[g]),
			.nv        (ax_nv[g])
		);
	end

	bpe_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ax_valid[0]),
		.nv_x      (ax_nv[0]),
		.nv_y      (ax_nv[1]),
		.out_valid (nrm_valid),
		.speed     (nrm_speed)
	);

	// Delay line that keeps the axis results beside the speed computation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NORM_LAT; i++) begin
				dv_q[i] <= 1'b0;
			end
		end else begin
			dv_q[0] <= ax_valid[0];
			for (int i = 1; i < NORM_LAT; i++) begin
				dv_q[i] <= dv_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_q[0] <= ax_res[0];
		dy_q[0] <= ax_res[1];
		for (int i = 1; i < NORM_LAT; i++) begin
			dx_q[i] <= dx_q[i-1];
			dy_q[i] <= dy_q[i-1];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_q[NORM_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		pos_x     <= dx_q[NORM_LAT-1].pos;
		vel_x     <= dx_q[NORM_LAT-1].vel;
		acc_x     <= dx_q[NORM_LAT-1].acc;
		pos_y     <= dy_q[NORM_LAT-1].pos;
		vel_y     <= dy_q[NORM_LAT-1].vel;
		acc_y     <= dy_q[NORM_LAT-1].acc;
		speed_mag <= nrm_speed;
	end

	assign done = done_q;

	`BPE_ASSERT(a_norm_aligned, nrm_valid == dv_q[NORM_LAT-1], "speed and axis results out of step")
	`BPE_ASSERT(a_axes_aligned, ax_valid[0] == ax_valid[1], "axis pipelines out of step")
	`BPE_ASSERT(a_latency, accept |-> ##LAT done, "accepted item gave no result on time")
	`BPE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done, "result strobe during reset")

endmodule

@@ sim/bpe_checker.sv @@
// Scoreboard for the Bezier point evaluator: predicts each result from the control points.
// Depends on bpe_pkg; watches the command, write and result ports of the block.
module bpe_checker import bpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [T_W-1:0]          t_value,
	input  logic                    wr_en,
	input  logic [IDX_W-1:0]        wr_index,
	input  logic [PT_W-1:0]         wr_data,
	input  logic                    done,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [VEL_W-1:0] vel_x,
	input  logic signed [VEL_W-1:0] vel_y,
	input  logic signed [ACC_W-1:0] acc_x,
	input  logic signed [ACC_W-1:0] acc_y,
	input  logic [SPD_W-1:0]        speed_mag,
	output int                      err_count,
	output int                      pending
);

	typedef struct {
		logic signed [POS_W-1:0] px, py;
		logic signed [VEL_W-1:0] vx, vy;
		logic signed [ACC_W-1:0] ax, ay;
		logic [SPD_W-1:0]        spd;
	} point_t;

	point_t curve_q[$];
	logic signed [PT_W-1:0] ctrl_pt[8];

	assign pending = curve_q.size();

	// Floor of x / 2^k; arithmetic shift floors already.
	function automatic longint floor_div(longint x, int k);
		return x >>> k;
	endfunction

	// Integer square root, bit by bit.
	function automatic longint unsigned int_sqrt(logic [127:0] n);
		logic [127:0] r, b;
		r = 0;
		b = 128'd1 << 126;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[63:0];
	endfunction

	// Bernstein form of the curve and its derivatives at one t.
	function automatic point_t eval_curve(logic [T_W-1:0] traw);
		point_t res;
		longint t, u, q0, q1, q2, q3, d0, d1, d2, np, nv[2], na;
		logic signed [127:0] sq;
		t = (traw > T_W'(ONE_T)) ? longint'(ONE_T) : longint'(traw);
		u = ONE_T - t;
		for (int a = 0; a < 2; a++) begin
			q0 = ctrl_pt[a]; q1 = ctrl_pt[2+a]; q2 = ctrl_pt[4+a]; q3 = ctrl_pt[6+a];
			d0 = q1 - q0; d1 = q2 - q1; d2 = q3 - q2;
			np = q0*u*u*u + 3*q1*u*u*t + 3*q2*u*t*t + q3*t*t*t;
			nv[a] = 3 * (d0*u*u + 2*d1*u*t + d2*t*t);
			na = 6 * ((d1 - d0)*u + (d2 - d1)*t);
			if (a == 0) begin
				res.px = POS_W'(floor_div(np, 36)); res.vx = VEL_W'(floor_div(nv[a], 24));
				res.ax = ACC_W'(floor_div(na, 12));
			end else begin
				res.py = POS_W'(floor_div(np, 36)); res.vy = VEL_W'(floor_div(nv[a], 24));
				res.ay = ACC_W'(floor_div(na, 12));
			end
		end
		sq = 128'(signed'(nv[0])) * 128'(signed'(nv[0]))
			+ 128'(signed'(nv[1])) * 128'(signed'(nv[1]));
		res.spd = SPD_W'(int_sqrt(sq >> 48));
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	initial err_count = 0;

	// Register writes, accepted items and result checks.
	always @(posedge clk or negedge arst_n) begin
		point_t w;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) ctrl_pt[i] = '0;
		end else begin
			if (done) begin
				if (curve_q.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					err_count++;
				end else begin
					w = curve_q.pop_front();
					if (pos_x !== w.px) report("pos_x", longint'(pos_x), longint'(w.px));
					if (pos_y !== w.py) report("pos_y", longint'(pos_y), longint'(w.py));
					if (vel_x !== w.vx) report("vel_x", longint'(vel_x), longint'(w.vx));
					if (vel_y !== w.vy) report("vel_y", longint'(vel_y), longint'(w.vy));
					if (acc_x !== w.ax) report("acc_x", longint'(acc_x), longint'(w.ax));
					if (acc_y !== w.ay) report("acc_y", longint'(acc_y), longint'(w.ay));
					if (speed_mag !== w.spd)
						report("speed_mag", longint'(speed_mag), longint'(w.spd));
				end
			end
			if (start && !busy) curve_q.push_back(eval_curve(t_value));
			if (wr_en) ctrl_pt[wr_index] = wr_data;
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top of the Bezier point evaluator: clock, reset, stimulus and verdict.
// Depends on bpe_pkg, bezier_point_evaluator and bpe_checker.
module tb;
	import bpe_pkg::*;

	logic clk = 0, arst_n = 0, start = 0, wr_en = 0, busy, done;
	logic [T_W-1:0] t_value = '0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [PT_W-1:0] wr_data = '0;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic signed [VEL_W-1:0] vel_x, vel_y;
	logic signed [ACC_W-1:0] acc_x, acc_y;
	logic [SPD_W-1:0] speed_mag;
	int err_count, pending;

	always #2 clk = ~clk;

	bezier_point_evaluator dut (.*);
	bpe_checker chk (.*);

	// Writes every control point register in turn.
	task automatic load_points(input logic [PT_W-1:0] v[8]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			wr_en <= 1'b1; wr_index <= reg_idx_t'(i); wr_data <= v[i];
		end
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Sends one item, then an optional random gap.
	task automatic send_t(input logic [T_W-1:0] tv, input bit gaps);
		int gap;
		start <= 1'b1; t_value <= tv;
		do @(posedge clk); while (busy);
		gap = gaps ? int'($urandom_range(0, 11)) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and lets the pipeline empty out.
	task automatic drain;
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		logic [PT_W-1:0] pts[8];
		logic [T_W-1:0] tv;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: reset points, then the extremes of t, including t above one.
		foreach (pts[i]) pts[i] = '0;
		send_t(0, 0); send_t(4096, 0);
		drain;
		pts = '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
			24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF};
		load_points(pts);
		send_t(0, 0); send_t(1, 0); send_t(2048, 0); send_t(4095, 0);
		send_t(4096, 0); send_t(4097, 0); send_t(13'h1FFF, 0); send_t(13'h0AAA, 0);
		send_t(13'h1555, 0);
		drain;
		pts = '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
			24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF};
		load_points(pts);
		send_t(0, 0); send_t(1024, 0); send_t(3072, 0); send_t(4096, 0);
		drain;
		// Random phases with new points each.
		for (int ph = 0; ph < 9; ph++) begin
			foreach (pts[i]) pts[i] = (ph == 0) ? 24'hFFFFFF : PT_W'($urandom());
			load_points(pts);
			for (int k = 0; k < 50; k++) begin
				case ($urandom_range(0, 9))
					0: tv = T_W'($urandom());
					1: tv = T_W'($urandom_range(4090, 4096));
					2: tv = T_W'($urandom_range(0, 5));
					default: tv = T_W'($urandom_range(0, 4096));
				endcase
				send_t(tv, ph % 3 != 2);
			end
			drain;
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
